>>> sv/lbfs_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the LED blink and fade sequencer.
// Used by lbfs_cfg_regs, lbfs_core and led_blink_fade_sequencer; no dependencies.
package lbfs_pkg;

  localparam int PWM_BITS = 8;
  localparam logic [7:0] FULL_SCALE =
    (PWM_BITS >= 8) ? 8'd255 : 8'((1 << PWM_BITS) - 1);

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_PERIOD  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_STEP    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK_TOGG   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_ROUNDS  = 3'd4;

  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_BLINK = 2'd1;
  localparam logic [1:0] PH_UP    = 2'd2;
  localparam logic [1:0] PH_DOWN  = 2'd3;

  typedef struct packed {
    logic [7:0] blink_period_ms;
    logic [7:0] fade_period_ms;
    logic [7:0] fade_step;
    logic [3:0] blink_toggles;
    logic [2:0] fade_rounds;
  } cfg_t;

endpackage

>>> sv/lbfs_cfg_regs.sv
`timescale 1ns / 1ps
// Configuration register file for the LED blink and fade sequencer.
// Depends on lbfs_pkg for the register indexes and the cfg_t bundle.
module lbfs_cfg_regs import lbfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.blink_period_ms <= 8'd250;
      cfg.fade_period_ms  <= 8'd10;
      cfg.fade_step       <= 8'd5;
      cfg.blink_toggles   <= 4'd8;
      cfg.fade_rounds     <= 3'd2;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLINK_PERIOD: cfg.blink_period_ms <= cfg_data;
        REG_FADE_PERIOD:  cfg.fade_period_ms  <= cfg_data;
        REG_FADE_STEP:    cfg.fade_step       <= cfg_data;
        REG_BLINK_TOGG:   cfg.blink_toggles   <= cfg_data[3:0];
        REG_FADE_ROUNDS:  cfg.fade_rounds     <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

endmodule

>>> sv/lbfs_core.sv
`timescale 1ns / 1ps
// Sequencer state and the per-tick next-state and duty logic.
// Depends on lbfs_pkg for phase codes, full scale and cfg_t.
module lbfs_core import lbfs_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic       level,
  input  cfg_t       cfg,
  output logic [7:0] duty_next,
  output logic [1:0] phase_next
);

  logic [1:0] phase;
  logic       last_button;
  logic       sequence_on;
  logic [7:0] elapsed;
  logic [3:0] toggle_count;
  logic [7:0] fade_level;
  logic [2:0] round_count;
  logic       blink_on;
  logic [7:0] held_duty;

  logic       sequence_on_next;
  logic [7:0] elapsed_next;
  logic [3:0] toggle_count_next;
  logic [7:0] fade_level_next;
  logic [2:0] round_count_next;
  logic       blink_on_next;
  logic [7:0] held_duty_next;

  logic       toggle;
  logic [7:0] elapsed_inc;
  logic [3:0] toggle_inc;
  logic [2:0] round_inc;
  logic [8:0] fade_sum;

  always_comb begin
    toggle           = (level == 1'b0) && last_button;
    sequence_on_next = sequence_on ^ toggle;
    phase_next       = phase;
    toggle_count_next = toggle_count;
    round_count_next = round_count;
    blink_on_next    = blink_on;
    if (toggle) begin
      phase_next        = sequence_on_next ? PH_BLINK : PH_IDLE;
      toggle_count_next = 4'd0;
      round_count_next  = 3'd0;
      blink_on_next     = 1'b0;
    end

    elapsed_inc     = (elapsed == 8'd255) ? elapsed : elapsed + 8'd1;
    elapsed_next    = elapsed_inc;
    fade_level_next = fade_level;
    held_duty_next  = held_duty;
    toggle_inc      = toggle_count_next + 4'd1;
    round_inc       = round_count_next + 3'd1;
    fade_sum        = {1'b0, fade_level} + {1'b0, cfg.fade_step};

    unique case (phase_next)
      PH_BLINK: begin
        if (elapsed_inc >= cfg.blink_period_ms) begin
          elapsed_next  = 8'd0;
          blink_on_next = ~blink_on_next;
          if (toggle_inc >= cfg.blink_toggles) begin
            toggle_count_next = 4'd0;
            held_duty_next    = blink_on_next ? FULL_SCALE : 8'd0;
            phase_next        = PH_UP;
          end else begin
            toggle_count_next = toggle_inc;
          end
        end
      end
      PH_UP: begin
        if (elapsed_inc >= cfg.fade_period_ms) begin
          elapsed_next   = 8'd0;
          held_duty_next = fade_level;
          if (fade_sum >= {1'b0, FULL_SCALE}) begin
            fade_level_next = FULL_SCALE;
            phase_next      = PH_DOWN;
          end else begin
            fade_level_next = fade_sum[7:0];
          end
        end
      end
      PH_DOWN: begin
        if (elapsed_inc >= cfg.fade_period_ms) begin
          elapsed_next   = 8'd0;
          held_duty_next = fade_level;
          if (fade_level <= cfg.fade_step) begin
            fade_level_next = 8'd0;
            if (round_inc < cfg.fade_rounds) begin
              round_count_next = round_inc;
              phase_next       = PH_UP;
            end else begin
              round_count_next = 3'd0;
              blink_on_next    = 1'b0;
              phase_next       = PH_BLINK;
            end
          end else begin
            fade_level_next = fade_level - cfg.fade_step;
          end
        end
      end
      default: ;
    endcase

    unique case (phase_next)
      PH_IDLE:  duty_next = 8'd0;
      PH_BLINK: duty_next = blink_on_next ? FULL_SCALE : 8'd0;
      default:  duty_next = held_duty_next;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_IDLE;
      last_button  <= 1'b1;
      sequence_on  <= 1'b0;
      elapsed      <= 8'd0;
      toggle_count <= 4'd0;
      fade_level   <= 8'd0;
      round_count  <= 3'd0;
      blink_on     <= 1'b0;
      held_duty    <= 8'd0;
    end else if (step) begin
      phase        <= phase_next;
      last_button  <= level;
      sequence_on  <= sequence_on_next;
      elapsed      <= elapsed_next;
      toggle_count <= toggle_count_next;
      fade_level   <= fade_level_next;
      round_count  <= round_count_next;
      blink_on     <= blink_on_next;
      held_duty    <= held_duty_next;
    end
  end

endmodule

>>> sv/led_blink_fade_sequencer.sv
`timescale 1ns / 1ps
// Top level of the LED blink and fade sequencer: input register, core, result register.
// Depends on lbfs_pkg, lbfs_cfg_regs and lbfs_core.
//
//   Channel   Handshake            Payload
//   input     in_valid/in_ready    button_level
//   result    out_valid/out_ready  led_duty, phase
//   config    cfg_we               cfg_index, cfg_data
//
// Each beat waits in the input register and the core is combinational, so the
// result register loads when the beat leaves the input register and out_valid
// rises as it loads. One beat is taken per cycle unless out_ready holds the result.
// The sequencer state updates in the same cycle as the result register loads.
// When the result register is held by out_ready low, the input register holds and
// in_ready drops once it is full. Reset clears the core state, in_full and out_valid.
module led_blink_fade_sequencer import lbfs_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  button_level,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [7:0]            led_duty,
  output logic [1:0]            phase,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  logic       in_full;
  logic       in_level;
  logic       advance;
  logic [7:0] duty_next;
  logic [1:0] phase_next;

  assign advance  = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || advance;

  lbfs_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lbfs_core u_core (
    .clk        (clk),
    .rst        (rst),
    .step       (advance),
    .level      (in_level),
    .cfg        (cfg),
    .duty_next  (duty_next),
    .phase_next (phase_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_level <= button_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      led_duty <= duty_next;
      phase    <= phase_next;
    end
  end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for led_blink_fade_sequencer: random button ticks under varied settings.
// Depends on lbfs_pkg and the sequencer RTL; a tracker class predicts each duty and phase.
module tb_top;
  import lbfs_pkg::*;

  typedef struct packed {
    logic [7:0] duty;
    logic [1:0] ph;
  } tick_result_t;

  class duty_tracker;
    cfg_t           cfg;
    logic [1:0]     ph_now;
    bit             last_btn;
    bit             seq_on;
    logic [7:0]     elapsed;
    logic [3:0]     toggles;
    logic [7:0]     level;
    logic [2:0]     rounds;
    bit             lamp_on;
    logic [7:0]     held;
    tick_result_t   duty_due[$];
    int             errors;
    int             checked;
    int             phase_hits[4];

    function new();
      cfg.blink_period_ms = 8'd250;
      cfg.fade_period_ms  = 8'd10;
      cfg.fade_step       = 8'd5;
      cfg.blink_toggles   = 4'd8;
      cfg.fade_rounds     = 3'd2;
      ph_now   = PH_IDLE;
      last_btn = 1'b1;
      seq_on   = 1'b0;
      elapsed  = '0;
      toggles  = '0;
      level    = '0;
      rounds   = '0;
      lamp_on  = 1'b0;
      held     = '0;
      errors   = 0;
      checked  = 0;
      foreach (phase_hits[i]) phase_hits[i] = 0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_BLINK_PERIOD: cfg.blink_period_ms = data;
        REG_FADE_PERIOD:  cfg.fade_period_ms  = data;
        REG_FADE_STEP:    cfg.fade_step       = data;
        REG_BLINK_TOGG:   cfg.blink_toggles   = data[3:0];
        REG_FADE_ROUNDS:  cfg.fade_rounds     = data[2:0];
        default: ;
      endcase
    endfunction

    function void note_tick(bit btn);
      int unsigned  nxt;
      tick_result_t r;
      if (!btn && last_btn) begin
        seq_on  = !seq_on;
        ph_now  = seq_on ? PH_BLINK : PH_IDLE;
        toggles = '0;
        rounds  = '0;
        lamp_on = 1'b0;
      end
      last_btn = btn;
      if (elapsed != 8'd255) elapsed++;
      case (ph_now)
        PH_BLINK: begin
          if (elapsed >= cfg.blink_period_ms) begin
            elapsed = '0;
            lamp_on = !lamp_on;
            toggles++;
            if (toggles >= cfg.blink_toggles) begin
              toggles = '0;
              held    = lamp_on ? FULL_SCALE : 8'd0;
              ph_now  = PH_UP;
            end
          end
        end
        PH_UP: begin
          if (elapsed >= cfg.fade_period_ms) begin
            elapsed = '0;
            held    = level;
            nxt     = int'(level) + int'(cfg.fade_step);
            if (nxt >= int'(FULL_SCALE)) begin
              level  = FULL_SCALE;
              ph_now = PH_DOWN;
            end else begin
              level = nxt[7:0];
            end
          end
        end
        PH_DOWN: begin
          if (elapsed >= cfg.fade_period_ms) begin
            elapsed = '0;
            held    = level;
            if (level <= cfg.fade_step) begin
              level = '0;
              rounds++;
              if (rounds < cfg.fade_rounds) begin
                ph_now = PH_UP;
              end else begin
                rounds  = '0;
                lamp_on = 1'b0;
                ph_now  = PH_BLINK;
              end
            end else begin
              level = level - cfg.fade_step;
            end
          end
        end
        default: ;
      endcase
      if (ph_now == PH_IDLE) r.duty = 8'd0;
      else if (ph_now == PH_BLINK) r.duty = lamp_on ? FULL_SCALE : 8'd0;
      else r.duty = held;
      r.ph = ph_now;
      duty_due.push_back(r);
    endfunction

    function void check_duty(logic [7:0] duty, logic [1:0] ph);
      tick_result_t exp_r;
      if (duty_due.size() == 0) begin
        $error("Result beat with nothing expected: led_duty %0d, phase %0d", duty, ph);
        errors++;
        return;
      end
      exp_r = duty_due.pop_front();
      checked++;
      phase_hits[exp_r.ph]++;
      if (duty !== exp_r.duty) begin
        $error("led_duty: expected %0d, got %0d", exp_r.duty, duty);
        errors++;
      end
      if (ph !== exp_r.ph) begin
        $error("phase: expected %0d, got %0d", exp_r.ph, ph);
        errors++;
      end
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  in_valid;
  logic                  in_ready;
  logic                  button_level;
  logic                  out_valid;
  logic                  out_ready;
  logic [7:0]            led_duty;
  logic [1:0]            phase;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  duty_tracker tracker = new();
  bit          src_gaps;
  bit          snk_stalls;
  int          press_left;
  int          ticks_sent;
  int          settings_used;

  led_blink_fade_sequencer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .button_level (button_level),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .led_duty     (led_duty),
    .phase        (phase),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) tracker.note_tick(button_level);
      if (out_valid && out_ready) tracker.check_duty(led_duty, phase);
    end
  end

  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (snk_stalls && $urandom_range(0, 9) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  task automatic send_tick(input bit btn);
    if (src_gaps && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    button_level <= btn;
    ticks_sent++;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.duty_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    tracker.set_reg(idx, data);
  endtask

  task automatic load_settings(input logic [7:0] bp, input logic [7:0] fp,
                               input logic [7:0] fs, input logic [3:0] bt,
                               input logic [2:0] fr);
    write_reg(REG_BLINK_PERIOD, bp);
    write_reg(REG_FADE_PERIOD, fp);
    write_reg(REG_FADE_STEP, fs);
    write_reg(REG_BLINK_TOGG, {4'd0, bt});
    write_reg(REG_FADE_ROUNDS, {5'd0, fr});
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic send_pattern(input logic [15:0] bits, input int count);
    for (int i = count - 1; i >= 0; i--) send_tick(bits[i]);
  endtask

  function automatic bit next_button(bit noisy);
    if (noisy) return 1'($urandom_range(0, 1));
    if (press_left > 0) begin
      press_left--;
      return 1'b0;
    end
    if ($urandom_range(0, 199) == 0) press_left = $urandom_range(0, 5);
    else return 1'b1;
    return 1'b0;
  endfunction

  function automatic logic [7:0] pick_period();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(1, 4));
  endfunction

  initial begin
    logic [7:0] bp;
    logic [7:0] fp;
    logic [7:0] fs;
    logic [3:0] bt;
    logic [2:0] fr;
    bit         noisy;
    rst          <= 1'b1;
    in_valid     <= 1'b0;
    button_level <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    src_gaps      = 1'b0;
    snk_stalls    = 1'b0;
    press_left    = 0;
    ticks_sent    = 0;
    settings_used = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: turn on with a press, then off with a second press.
    send_pattern(16'b1011_0011, 8);
    drain_results();
    // Shortest periods and full step: blink, clamp at full scale, clamp at zero.
    load_settings(8'd1, 8'd1, 8'd255, 4'd1, 3'd1);
    send_pattern(16'b1011_1111_1111, 12);
    drain_results();
    // Zero settings: every tick acts and a zero step never leaves the ramp.
    load_settings(8'd0, 8'd0, 8'd0, 4'd0, 3'd0);
    send_pattern(16'b0101_1111, 8);
    drain_results();

    for (int p = 0; p < 14; p++) begin
      case (p)
        0: begin bp = 8'd255; fp = 8'd255; fs = 8'd255; bt = 4'd15; fr = 3'd7; end
        1: begin bp = 8'd1; fp = 8'd1; fs = 8'd1; bt = 4'd15; fr = 3'd7; end
        2: begin bp = 8'd1; fp = 8'd1; fs = 8'd255; bt = 4'd1; fr = 3'd1; end
        default: begin
          bp = pick_period();
          fp = pick_period();
          fs = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(20, 255));
          bt = 4'($urandom_range(0, 15));
          fr = 3'($urandom_range(0, 7));
        end
      endcase
      load_settings(bp, fp, fs, bt, fr);
      noisy      = (p % 5 == 3);
      src_gaps   = (p != 13) && ($urandom_range(0, 3) != 0);
      snk_stalls = (p != 13) && ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 125; i++) send_tick(next_button(noisy));
      drain_results();
    end

    repeat (10) @(posedge clk);
    if (tracker.duty_due.size() != 0) begin
      $error("%0d expected results never arrived", tracker.duty_due.size());
      tracker.errors++;
    end
    $display("Sent %0d button ticks across %0d register settings; checked %0d results.",
             ticks_sent, settings_used, tracker.checked);
    $display("Results by phase: idle %0d, blink %0d, fade up %0d, fade down %0d.",
             tracker.phase_hits[0], tracker.phase_hits[1],
             tracker.phase_hits[2], tracker.phase_hits[3]);
    if (tracker.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
